// File: sv/morph3_pkg.sv
package morph3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int OUT_DEPTH_DEFAULT = 4;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int MODE_W         = 2;
    localparam int PIXEL_W        = 8;
    localparam int ROW_W          = 14;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd1024;
    localparam logic [PIXEL_W-1:0]        PIXEL_MAX          = 8'd255;
    localparam logic [PIXEL_W-1:0]        PIXEL_MIN          = 8'd0;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_FILTER_MODE  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BIN_ERODE   = 2'd0,
        MODE_BIN_DILATE  = 2'd1,
        MODE_GRAY_ERODE  = 2'd2,
        MODE_GRAY_DILATE = 2'd3
    } mode_t;

    typedef struct packed {
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
    } border_t;

    typedef logic [2:0][2:0][PIXEL_W-1:0] window_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               end_of_frame;
    } result_t;

endpackage

// File: sv/morph3_if.sv
interface morph3_pix_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [morph3_pkg::PIXEL_W-1:0] pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink (input valid, input op, input pixel_in, output ready);
endinterface

interface morph3_res_if;
    logic                          valid;
    logic                          ready;
    logic [morph3_pkg::PIXEL_W-1:0] pixel_out;
    logic                          end_of_frame;

    modport source (output valid, output pixel_out, output end_of_frame, input ready);
    modport sink (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

interface morph3_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [morph3_pkg::CFG_INDEX_W-1:0] index;
    logic [morph3_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/morph3_kernel.sv
module morph3_kernel (
    input  morph3_pkg::window_t               window,
    input  morph3_pkg::border_t               border,
    input  morph3_pkg::mode_t                 mode,
    output logic [morph3_pkg::PIXEL_W-1:0]    result
);

    logic [morph3_pkg::PIXEL_W-1:0] center;
    logic [morph3_pkg::PIXEL_W-1:0] lo;
    logic [morph3_pkg::PIXEL_W-1:0] hi;
    logic [2:0]                     row_ok;
    logic [2:0]                     col_ok;
    logic                           interior;
    logic                           hit_zero;
    logic                           hit_nonzero;

    always_comb
    begin
        center      = window[1][1];
        row_ok      = {border.down_ok, 1'b1, border.up_ok};
        col_ok      = {border.right_ok, 1'b1, border.left_ok};
        interior    = border.up_ok && border.down_ok && border.left_ok && border.right_ok;
        hit_zero    = 1'b0;
        hit_nonzero = 1'b0;
        lo          = morph3_pkg::PIXEL_MAX;
        hi          = morph3_pkg::PIXEL_MIN;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!(r == 1 && c == 1))
                begin
                    if (window[r][c] == morph3_pkg::PIXEL_MIN)
                        hit_zero = 1'b1;
                    else
                        hit_nonzero = 1'b1;
                end
                if (row_ok[r] && col_ok[c])
                begin
                    if (window[r][c] < lo)
                        lo = window[r][c];
                    if (window[r][c] > hi)
                        hi = window[r][c];
                end
            end
        end

        unique case (mode)
            morph3_pkg::MODE_BIN_ERODE:
                result = (interior && center != morph3_pkg::PIXEL_MIN && hit_zero)
                       ? morph3_pkg::PIXEL_MIN : center;
            morph3_pkg::MODE_BIN_DILATE:
                result = (interior && center == morph3_pkg::PIXEL_MIN && hit_nonzero)
                       ? morph3_pkg::PIXEL_MAX : center;
            morph3_pkg::MODE_GRAY_ERODE:
                result = lo;
            default:
                result = hi;
        endcase
    end

endmodule

// File: sv/morph3_out_fifo.sv
module morph3_out_fifo #(
    parameter int DEPTH = morph3_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  morph3_pkg::result_t           push_data,
    input  logic                          pop,
    output logic                          out_valid,
    output morph3_pkg::result_t           out_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    morph3_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: sv/morphology_3x3_filter_unit.sv
// Streaming 3x3 morphology filter. It takes one word per clock on the pixel channel and
// gives one filtered pixel per clock on the result channel, each while its ready is high;
// the rate is set by the line memory, which holds the two rows above as one 16-bit entry
// per column and is read and written once for every word. The result for pixel (r, c) comes
// from the word for (r+1, c+1), so a frame of W columns needs exactly W+1 flush words after
// its last pixel to drain, and the last result carries end_of_frame. Flush words taken before
// a frame's pixels are complete, and pixels taken while a frame drains, are dropped without a
// result. The line memory needs no clearing after reset. The user must write configuration
// only while no word is in flight; the block itself does not enforce this.
module morphology_3x3_filter_unit #(
    parameter int MAX_WIDTH = morph3_pkg::MAX_WIDTH_DEFAULT,
    parameter int OUT_DEPTH = morph3_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    morph3_pix_if.sink   pixels,
    morph3_res_if.source results,
    morph3_cfg_if.sink   cfg
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (WW > morph3_pkg::FRAME_WIDTH_W) ? WW : morph3_pkg::FRAME_WIDTH_W;
    localparam int RW    = morph3_pkg::ROW_W;
    localparam int PW    = morph3_pkg::PIXEL_W;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration registers.
    logic [morph3_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [morph3_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    morph3_pkg::mode_t                     filter_mode_reg;
    morph3_pkg::cfg_index_t                cfg_index;

    // Frame counters.
    logic [CW-1:0] in_col_reg;
    logic [CW-1:0] in_col_next;
    logic [RW-1:0] in_row_reg;
    logic [RW-1:0] in_row_next;
    logic [CW-1:0] out_col_reg;
    logic [CW-1:0] out_col_next;
    logic [RW-1:0] out_row_reg;
    logic [RW-1:0] out_row_next;
    logic          complete_reg;
    logic          complete_next;

    logic [WW-1:0] width_eff;
    logic [CW-1:0] width_m1;
    logic [RW-1:0] height_eff;
    logic [CW-1:0] in_col_eff;
    logic [CW-1:0] out_col_eff;
    logic [WW-1:0] in_col_p1;
    logic [WW-1:0] out_col_p1;
    logic [RW-1:0] in_row_p1;
    logic [RW-1:0] out_row_p1;

    logic                accept;
    logic                proceed;
    logic                emit;
    logic                eof;
    logic [PW-1:0]       new_pixel;
    morph3_pkg::border_t border;

    // Line memory.
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] line_q_reg;
    logic            fwd_hit_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic [2*PW-1:0] line_rd;
    logic [2*PW-1:0] line_wr;

    // Stage 1: memory data returns, window shifts, memory is written back.
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_eof_reg;
    morph3_pkg::border_t s1_border_reg;
    logic [CW-1:0]       s1_addr_reg;
    logic [PW-1:0]       s1_pixel_reg;

    morph3_pkg::window_t window_reg;
    morph3_pkg::window_t window_next;

    // Stage 2: result is formed and pushed into the output buffer.
    logic                s2_valid_reg;
    logic                s2_eof_reg;
    morph3_pkg::border_t s2_border_reg;
    logic [PW-1:0]       s2_result;

    morph3_pkg::result_t push_data;
    morph3_pkg::result_t head;
    logic                head_valid;
    logic [CNT_W-1:0]    fifo_count;
    logic [CNT_W:0]      in_flight;

    assign cfg.ready = 1'b1;
    assign cfg_index = morph3_pkg::cfg_index_t'(cfg.index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= morph3_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= morph3_pkg::FRAME_HEIGHT_RESET;
            filter_mode_reg  <= morph3_pkg::MODE_BIN_ERODE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index)
                morph3_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg.data[morph3_pkg::FRAME_WIDTH_W-1:0];
                morph3_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg.data[morph3_pkg::FRAME_HEIGHT_W-1:0];
                morph3_pkg::CFG_FILTER_MODE:
                    filter_mode_reg <= morph3_pkg::mode_t'(cfg.data[morph3_pkg::MODE_W-1:0]);
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = WW'(1);
        else if (XW'(frame_width_reg) > XW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(frame_width_reg);
        width_m1 = CW'(width_eff - 1'b1);
        if (frame_height_reg == '0)
            height_eff = RW'(1);
        else
            height_eff = RW'(frame_height_reg);
    end

    assign in_col_eff  = (WW'(in_col_reg) >= width_eff) ? width_m1 : in_col_reg;
    assign out_col_eff = (WW'(out_col_reg) >= width_eff) ? width_m1 : out_col_reg;
    assign in_col_p1   = WW'(in_col_eff) + 1'b1;
    assign out_col_p1  = WW'(out_col_eff) + 1'b1;
    assign in_row_p1   = in_row_reg + 1'b1;
    assign out_row_p1  = out_row_reg + 1'b1;

    assign in_flight    = CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg) + (CNT_W+1)'(fifo_count);
    assign pixels.ready = (in_flight < (CNT_W+1)'(OUT_DEPTH));
    assign accept       = pixels.valid && pixels.ready;
    assign proceed      = accept && ((pixels.op == morph3_pkg::OP_FLUSH) == complete_reg);
    assign new_pixel    = (pixels.op == morph3_pkg::OP_PIXEL) ? pixels.pixel_in
                                                              : morph3_pkg::PIXEL_MIN;
    assign emit         = (in_row_reg > RW'(1)) || (in_row_reg == RW'(1) && in_col_eff != '0);
    assign eof          = (out_row_p1 >= height_eff) && (out_col_p1 >= width_eff);

    assign border.up_ok    = (out_row_reg != '0);
    assign border.down_ok  = (out_row_p1 < height_eff);
    assign border.left_ok  = (out_col_eff != '0);
    assign border.right_ok = (out_col_p1 < width_eff);

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        complete_next = complete_reg;
        if (accept)
        begin
            in_col_next  = in_col_eff;
            out_col_next = out_col_eff;
        end
        if (proceed)
        begin
            if (pixels.op == morph3_pkg::OP_PIXEL && in_row_p1 >= height_eff
                && in_col_p1 >= width_eff)
                complete_next = 1'b1;
            if (in_col_p1 >= width_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_p1;
            end
            else
            begin
                in_col_next = CW'(in_col_p1);
            end
            if (emit)
            begin
                if (out_col_p1 >= width_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_p1;
                end
                else
                begin
                    out_col_next = CW'(out_col_p1);
                end
                if (eof)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    complete_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            complete_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            complete_reg <= complete_next;
            s1_valid_reg <= proceed;
            s1_emit_reg  <= emit;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            fwd_hit_reg  <= s1_valid_reg && (s1_addr_reg == in_col_eff);
        end
    end

    // The entry written at the edge where a word is taken is not yet visible in the
    // registered read data, so that write is caught and forwarded instead.
    assign line_rd = fwd_hit_reg ? fwd_data_reg : line_q_reg;
    assign line_wr = {line_rd[PW-1:0], s1_pixel_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= line_wr;
        if (proceed)
            line_q_reg <= line_mem[in_col_eff];
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= line_wr;
        if (proceed)
        begin
            s1_addr_reg   <= in_col_eff;
            s1_pixel_reg  <= new_pixel;
            s1_eof_reg    <= eof;
            s1_border_reg <= border;
        end
        if (s1_valid_reg)
        begin
            window_reg    <= window_next;
            s2_eof_reg    <= s1_eof_reg;
            s2_border_reg <= s1_border_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = line_rd[2*PW-1:PW];
        window_next[1][2] = line_rd[PW-1:0];
        window_next[2][2] = s1_pixel_reg;
    end

    morph3_kernel u_kernel (
        .window (window_reg),
        .border (s2_border_reg),
        .mode   (filter_mode_reg),
        .result (s2_result)
    );

    assign push_data.pixel_out    = s2_result;
    assign push_data.end_of_frame = s2_eof_reg;

    morph3_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .pop       (head_valid && results.ready),
        .out_valid (head_valid),
        .out_data  (head),
        .count     (fifo_count)
    );

    assign results.valid        = head_valid;
    assign results.pixel_out    = head.pixel_out;
    assign results.end_of_frame = head.end_of_frame;

endmodule

// File: tb/tb_morphology_3x3_filter_unit.sv
module tb_morphology_3x3_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX      = morph3_pkg::MAX_WIDTH_DEFAULT;
    localparam int PX_W          = morph3_pkg::PIXEL_W;
    localparam int CD_W          = morph3_pkg::CFG_DATA_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 500;
    localparam int CYCLE_LIMIT   = 3000000;

    logic clk = 1'b0;
    logic rst_n;

    morph3_pix_if pix_bus ();
    morph3_res_if res_bus ();
    morph3_cfg_if cfg_bus ();

    morphology_3x3_filter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_bus),
        .results (res_bus),
        .cfg     (cfg_bus)
    );

    always #2 clk = ~clk;

    // Mirror of the filter: two rows above, the 3x3 neighborhood and the raster counters.
    logic [PX_W-1:0]                           line_mem [2*LINE_MAX];
    logic [PX_W-1:0]                           nbhd [9];
    int unsigned                               col_in, row_in, col_out, row_out;
    bit                                        frame_fed;
    logic [morph3_pkg::FRAME_WIDTH_W-1:0]      cur_width;
    logic [morph3_pkg::FRAME_HEIGHT_W-1:0]     cur_height;
    morph3_pkg::mode_t                         cur_mode;

    morph3_pkg::result_t awaited_pixels [$];
    morph3_pkg::result_t got;
    morph3_pkg::result_t want;
    int unsigned words_taken, words_dropped, frames_closed;
    int unsigned results_seen = 0;
    int unsigned failures = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          tx_steady, rx_steady;

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return morph3_pkg::PIXEL_MIN;
        if (r < 40)
            return morph3_pkg::PIXEL_MAX;
        return PX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PX_W-1:0] morph_window(int unsigned w, int unsigned h);
        bit              row_ok [3];
        bit              col_ok [3];
        bit              hit;
        bit              binary;
        logic [PX_W-1:0] acc;
        logic [PX_W-1:0] pix;
        logic [PX_W-1:0] center;
        int              r;
        int              c;
        row_ok[0] = row_out > 0;
        row_ok[1] = 1'b1;
        row_ok[2] = row_out + 1 < h;
        col_ok[0] = col_out > 0;
        col_ok[1] = 1'b1;
        col_ok[2] = col_out + 1 < w;
        center = nbhd[4];
        binary = (cur_mode == morph3_pkg::MODE_BIN_ERODE)
              || (cur_mode == morph3_pkg::MODE_BIN_DILATE);
        if (binary)
        begin
            if (!(row_ok[0] && row_ok[2] && col_ok[0] && col_ok[2]))
                return center;
            hit = 1'b0;
            for (r = 0; r < 3; r++)
            begin
                for (c = 0; c < 3; c++)
                begin
                    pix = nbhd[r*3+c];
                    if (!(r == 1 && c == 1))
                    begin
                        if (cur_mode == morph3_pkg::MODE_BIN_ERODE
                            ? (pix == morph3_pkg::PIXEL_MIN) : (pix != morph3_pkg::PIXEL_MIN))
                            hit = 1'b1;
                    end
                end
            end
            if (cur_mode == morph3_pkg::MODE_BIN_ERODE)
                return (center != morph3_pkg::PIXEL_MIN && hit) ? morph3_pkg::PIXEL_MIN
                                                                  : center;
            return (center == morph3_pkg::PIXEL_MIN && hit) ? morph3_pkg::PIXEL_MAX : center;
        end
        acc = (cur_mode == morph3_pkg::MODE_GRAY_ERODE) ? morph3_pkg::PIXEL_MAX
                                                          : morph3_pkg::PIXEL_MIN;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                pix = nbhd[r*3+c];
                if (row_ok[r] && col_ok[c])
                begin
                    if (cur_mode == morph3_pkg::MODE_GRAY_ERODE ? (pix < acc) : (pix > acc))
                        acc = pix;
                end
            end
        end
        return acc;
    endfunction

    function automatic void filter_step(logic op, logic [PX_W-1:0] px);
        int unsigned         w;
        int unsigned         h;
        logic [PX_W-1:0]     up2;
        logic [PX_W-1:0]     up1;
        logic [PX_W-1:0]     v;
        bit                  emit;
        bit                  eof;
        morph3_pkg::result_t r;
        w = cur_width;
        if (w < 1)
            w = 1;
        if (w > LINE_MAX)
            w = LINE_MAX;
        h = cur_height;
        if (h < 1)
            h = 1;
        if (col_in >= w)
            col_in = w - 1;
        if (col_out >= w)
            col_out = w - 1;
        if ((op == morph3_pkg::OP_PIXEL && frame_fed)
            || (op == morph3_pkg::OP_FLUSH && !frame_fed))
        begin
            words_dropped++;
            return;
        end
        words_taken++;
        v = (op == morph3_pkg::OP_PIXEL) ? px : morph3_pkg::PIXEL_MIN;
        up2 = line_mem[col_in];
        up1 = line_mem[LINE_MAX+col_in];
        line_mem[col_in] = up1;
        line_mem[LINE_MAX+col_in] = v;
        nbhd[0] = nbhd[1];
        nbhd[1] = nbhd[2];
        nbhd[2] = up2;
        nbhd[3] = nbhd[4];
        nbhd[4] = nbhd[5];
        nbhd[5] = up1;
        nbhd[6] = nbhd[7];
        nbhd[7] = nbhd[8];
        nbhd[8] = v;
        emit = row_in > 1 || (row_in == 1 && col_in >= 1);
        if (op == morph3_pkg::OP_PIXEL && row_in + 1 >= h && col_in + 1 >= w)
            frame_fed = 1'b1;
        col_in++;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end
        if (!emit)
            return;
        eof = row_out + 1 >= h && col_out + 1 >= w;
        r.pixel_out = morph_window(w, h);
        r.end_of_frame = eof;
        awaited_pixels.push_back(r);
        col_out++;
        if (col_out >= w)
        begin
            col_out = 0;
            row_out++;
        end
        if (eof)
        begin
            col_in = 0;
            row_in = 0;
            col_out = 0;
            row_out = 0;
            frame_fed = 1'b0;
            frames_closed++;
        end
    endfunction

    // Entered and left at a falling edge; the word is taken at the rising edge in between.
    task automatic send_word(logic op, logic [PX_W-1:0] px);
        int unsigned gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.op <= op;
        pix_bus.pixel_in <= px;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        filter_step(op, px);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (awaited_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(morph3_pkg::cfg_index_t idx, logic [CD_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            morph3_pkg::CFG_FRAME_WIDTH:
                cur_width = value[morph3_pkg::FRAME_WIDTH_W-1:0];
            morph3_pkg::CFG_FRAME_HEIGHT:
                cur_height = value[morph3_pkg::FRAME_HEIGHT_W-1:0];
            morph3_pkg::CFG_FILTER_MODE:
                cur_mode = morph3_pkg::mode_t'(value[morph3_pkg::MODE_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, morph3_pkg::mode_t m);
        wait_idle();
        write_reg(morph3_pkg::CFG_FRAME_WIDTH, CD_W'(w));
        write_reg(morph3_pkg::CFG_FRAME_HEIGHT, CD_W'(h));
        write_reg(morph3_pkg::CFG_FILTER_MODE, CD_W'(m));
    endtask

    // Feeds pixels until the frame is complete, then flushes until it closes; noise_pct mixes in out-of-sequence words.
    task automatic run_frame(int unsigned noise_pct);
        while (!frame_fed)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(morph3_pkg::OP_FLUSH, PX_W'($urandom_range(0, 255)));
            send_word(morph3_pkg::OP_PIXEL, pick_pixel());
        end
        while (frame_fed)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(morph3_pkg::OP_PIXEL, pick_pixel());
            send_word(morph3_pkg::OP_FLUSH, PX_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        configure(3, 3, morph3_pkg::MODE_BIN_ERODE);
        send_word(morph3_pkg::OP_FLUSH, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MIN);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        send_word(morph3_pkg::OP_PIXEL, 8'd128);
        send_word(morph3_pkg::OP_PIXEL, 8'd77);
        repeat (4) send_word(morph3_pkg::OP_FLUSH, morph3_pkg::PIXEL_MIN);
        configure(2, 1, morph3_pkg::MODE_GRAY_DILATE);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MIN);
        send_word(morph3_pkg::OP_PIXEL, morph3_pkg::PIXEL_MAX);
        repeat (3) send_word(morph3_pkg::OP_FLUSH, 8'h5A);
    endtask

    task automatic test_width_shrink();
        configure(4, 3, morph3_pkg::MODE_GRAY_ERODE);
        repeat (6) send_word(morph3_pkg::OP_PIXEL, pick_pixel());
        wait_idle();
        write_reg(morph3_pkg::CFG_FRAME_WIDTH, CD_W'(2));
        run_frame(0);
    endtask

    task automatic test_extreme_sizes();
        configure(1, 1, morph3_pkg::MODE_BIN_ERODE);
        run_frame(0);
        configure(160, 1, morph3_pkg::MODE_GRAY_DILATE);
        run_frame(0);
        configure(40, 3, morph3_pkg::MODE_GRAY_ERODE);
        run_frame(0);
        configure(1, 100, morph3_pkg::MODE_BIN_DILATE);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned lead;
        int unsigned noise;
        start = words_taken;
        while (words_taken - start < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            else if (r < 97)
            begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 12);
            end
            else
            begin
                w = $urandom_range(50, 120);
                h = $urandom_range(1, 2);
            end
            if ($urandom_range(0, 9) != 0)
                configure(w, h, morph3_pkg::mode_t'($urandom_range(0, 3)));
            tx_steady = $urandom_range(0, 99) < 15;
            rx_steady = $urandom_range(0, 99) < 15;
            noise = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(10, 30);
            if ($urandom_range(0, 9) == 0)
            begin
                lead = $urandom_range(0, w * h - 1);
                repeat (lead) send_word(morph3_pkg::OP_PIXEL, pick_pixel());
                wait_idle();
                case ($urandom_range(0, 2))
                    0: write_reg(morph3_pkg::CFG_FRAME_WIDTH, CD_W'($urandom_range(1, w)));
                    1: write_reg(morph3_pkg::CFG_FRAME_HEIGHT,
                                 CD_W'($urandom_range(1, h + 2)));
                    default: write_reg(morph3_pkg::CFG_FILTER_MODE,
                                       CD_W'($urandom_range(0, 3)));
                endcase
            end
            run_frame(noise);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 20)
                stall_left = pick_gap(1'b0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.pixel_out = res_bus.pixel_out;
            got.end_of_frame = res_bus.end_of_frame;
            results_seen++;
            if (awaited_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d, end_of_frame %0b",
                       got.pixel_out, got.end_of_frame);
                failures++;
            end
            else
            begin
                want = awaited_pixels.pop_front();
                if (got.pixel_out !== want.pixel_out)
                begin
                    $error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
                    failures++;
                end
                if (got.end_of_frame !== want.end_of_frame)
                begin
                    $error("end_of_frame: expected %0b, actual %0b",
                           want.end_of_frame, got.end_of_frame);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.op = morph3_pkg::OP_PIXEL;
        pix_bus.pixel_in = morph3_pkg::PIXEL_MIN;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = morph3_pkg::CFG_FRAME_WIDTH;
        cfg_bus.data = '0;
        for (int i = 0; i < 2 * LINE_MAX; i++)
            line_mem[i] = morph3_pkg::PIXEL_MIN;
        for (int i = 0; i < 9; i++)
            nbhd[i] = morph3_pkg::PIXEL_MIN;
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        frame_fed = 1'b0;
        cur_width = morph3_pkg::FRAME_WIDTH_RESET;
        cur_height = morph3_pkg::FRAME_HEIGHT_RESET;
        cur_mode = morph3_pkg::MODE_BIN_ERODE;
        words_taken = 0;
        words_dropped = 0;
        frames_closed = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_width_shrink();
        test_extreme_sizes();
        test_random_frames();

        wait_idle();
        repeat (16) @(negedge clk);
        $display("Fed %0d words (%0d more dropped out of sequence);",
                 words_taken, words_dropped);
        $display("checked %0d results in %0d frames, all four modes, 1x1 up to 160x1 and 1x100.",
                 results_seen, frames_closed);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
